>>> src/sfr_pkg.sv
// Shared types and constants of the SLIP frame receiver.
// Used by slip_frame_receiver; depends on nothing.
package sfr_pkg;

  localparam int BUF_DEPTH_DEF = 256;

  localparam int CFG_IDX_W = 8;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_END_CODE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_CODE     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_END_CODE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC_ESC_CODE = 8'd3;

  localparam logic [BYTE_W-1:0] END_CODE_RST     = 8'd192;
  localparam logic [BYTE_W-1:0] ESC_CODE_RST     = 8'd219;
  localparam logic [BYTE_W-1:0] ESC_END_CODE_RST = 8'd220;
  localparam logic [BYTE_W-1:0] ESC_ESC_CODE_RST = 8'd221;

  typedef enum logic [1:0] {
    MODE_HUNT  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_ESC   = 2'd2,
    MODE_DONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REQ_BYTE    = 2'd0,
    REQ_RESTART = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_READ    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_DONE    = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  // Result of one transfer while the buffer read is in flight.
  typedef struct packed {
    status_t           status;
    logic [LEN_W-1:0]  frame_len;
    logic [BYTE_W-1:0] pkt_type;
    logic              rd_ok;
  } res_t;

endpackage

>>> src/sfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Uses no package; instantiated by slip_frame_receiver for the frame buffer.
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/slip_frame_receiver.sv
// SLIP frame receiver: line-byte unescaping, frame buffer and read-back.
// Depends on sfr_pkg for types and constants and on sfr_ram for the buffer.
//
// Usage: each input transfer carries a request (line byte, restart, timeout
// or read of a stored data byte). Every request produces exactly one result
// transfer on the out_ channel, in request order. Line bytes are hunted for
// a delimiter, unescaped and stored; a delimiter after at least one stored
// byte reports the frame length and its first byte (the packet type), and
// further line bytes are ignored until a restart or timeout.
// A request is registered in the stage beside the RAM read and then in
// the output register, which drives out_valid. One request is taken per
// cycle while in_stall is low: the frame buffer write and the read for a
// data byte use the separate write and read ports of the RAM, so there
// is no contention. The result waits in an output register; while it is
// stalled one more request can still be taken, held in the stage beside the
// RAM read register, and only then does in_stall rise.
// Reset (synchronous, rst_n low) puts the receiver into hunting with an
// empty buffer, loads the default codes and drops both valid flags. The
// buffer contents are not cleared; only entries below the count are read.
// Configuration writes on cfg_ should only be issued while no request is in
// flight; the block does not hold them back.
module slip_frame_receiver #(
  parameter int BUF_DEPTH = sfr_pkg::BUF_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::BYTE_W-1:0]      cfg_wdata,
  // Request channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_req_type,
  input  logic [sfr_pkg::BYTE_W-1:0]      in_rx_byte,
  input  logic [sfr_pkg::BYTE_W-1:0]      in_read_index,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic [sfr_pkg::LEN_W-1:0]       out_frame_len,
  output logic [sfr_pkg::BYTE_W-1:0]      out_pkt_type,
  output logic [sfr_pkg::BYTE_W-1:0]      out_read_data
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  // The count must be able to hold BUF_DEPTH itself.
  localparam int CW = $clog2(BUF_DEPTH + 1);
  // Comparison width for the read position against the count.
  localparam int PW = (CW > sfr_pkg::LEN_W) ? CW : sfr_pkg::LEN_W;
  localparam logic [CW-1:0] DEPTH_CNT = CW'(BUF_DEPTH);
  localparam logic [PW-1:0] DEPTH_POS = PW'(BUF_DEPTH);

  // Configuration registers.
  logic [sfr_pkg::BYTE_W-1:0] end_code_r, esc_code_r, esc_end_code_r, esc_esc_code_r;

  // Receiver state.
  sfr_pkg::mode_t             mode_r, mode_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [sfr_pkg::BYTE_W-1:0] first_r, first_nxt;

  // Pipeline: stage beside the RAM read, then the output register.
  logic                       s1_valid_r, s1_valid_nxt;
  sfr_pkg::res_t              s1_r, s1_nxt;
  logic                       out_valid_r, out_valid_nxt;
  sfr_pkg::res_t              out_r;
  logic [sfr_pkg::BYTE_W-1:0] out_rdata_r;

  logic                       in_accept;
  logic                       s1_adv;
  sfr_pkg::req_t              req;

  logic                       store_req;
  logic [sfr_pkg::BYTE_W-1:0] store_val;
  logic                       store_full;
  logic                       esc_bad;
  logic                       discard;
  logic                       frame_end;

  logic [PW-1:0]              pos;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [AW-1:0]              ram_raddr;
  logic [sfr_pkg::BYTE_W-1:0] ram_rdata;

  // Handshake. The stage beside the RAM moves on whenever the output
  // register is empty or its result is being transferred.
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign req       = sfr_pkg::req_t'(in_req_type);

  // Configuration. Writes to an index beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_code_r     <= sfr_pkg::END_CODE_RST;
      esc_code_r     <= sfr_pkg::ESC_CODE_RST;
      esc_end_code_r <= sfr_pkg::ESC_END_CODE_RST;
      esc_esc_code_r <= sfr_pkg::ESC_ESC_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sfr_pkg::CFG_END_CODE:     end_code_r     <= cfg_wdata;
        sfr_pkg::CFG_ESC_CODE:     esc_code_r     <= cfg_wdata;
        sfr_pkg::CFG_ESC_END_CODE: esc_end_code_r <= cfg_wdata;
        sfr_pkg::CFG_ESC_ESC_CODE: esc_esc_code_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Byte decode: which line bytes turn into a buffer store, and of what.
  // Inside a frame the escape test is made first, so it wins when the
  // escape and delimiter codes are equal.
  always_comb begin
    store_req = 1'b0;
    store_val = in_rx_byte;
    esc_bad   = 1'b0;
    frame_end = 1'b0;
    if (in_accept && req == sfr_pkg::REQ_BYTE) begin
      case (mode_r)
        sfr_pkg::MODE_ESC: begin
          if (in_rx_byte == esc_end_code_r) begin
            store_req = 1'b1;
            store_val = end_code_r;
          end else if (in_rx_byte == esc_esc_code_r) begin
            store_req = 1'b1;
            store_val = esc_code_r;
          end else begin
            esc_bad = 1'b1;
          end
        end
        sfr_pkg::MODE_FRAME: begin
          if (in_rx_byte == esc_code_r) begin
            store_req = 1'b0;
          end else if (in_rx_byte == end_code_r) begin
            frame_end = (count_r != '0);
          end else begin
            store_req = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // A store into a full buffer throws the frame away instead.
  assign store_full = (count_r == DEPTH_CNT);
  assign discard    = (in_accept && (req == sfr_pkg::REQ_RESTART ||
                                     req == sfr_pkg::REQ_TIMEOUT))
                      || esc_bad || (store_req && store_full);

  // Next mode.
  always_comb begin
    mode_nxt = mode_r;
    if (discard) begin
      mode_nxt = sfr_pkg::MODE_HUNT;
    end else if (in_accept && req == sfr_pkg::REQ_BYTE) begin
      case (mode_r)
        sfr_pkg::MODE_HUNT: begin
          if (in_rx_byte == end_code_r) begin
            mode_nxt = sfr_pkg::MODE_FRAME;
          end
        end
        sfr_pkg::MODE_FRAME: begin
          if (in_rx_byte == esc_code_r) begin
            mode_nxt = sfr_pkg::MODE_ESC;
          end else if (frame_end) begin
            mode_nxt = sfr_pkg::MODE_DONE;
          end
        end
        sfr_pkg::MODE_ESC: mode_nxt = sfr_pkg::MODE_FRAME;
        default: ;
      endcase
    end
  end

  // Count, first byte and buffer write.
  assign ram_we    = store_req && !store_full;
  assign ram_waddr = count_r[AW-1:0];

  always_comb begin
    count_nxt = count_r;
    first_nxt = first_r;
    if (discard) begin
      count_nxt = '0;
    end else if (ram_we) begin
      count_nxt = count_r + CW'(1);
      if (count_r == '0) begin
        first_nxt = store_val;
      end
    end
  end

  // Result of the accepted request. The RAM read register loads the data byte
  // with this stage; rd_ok marks whether the position holds a stored byte.
  assign pos       = PW'(in_read_index) + PW'(1);
  assign ram_raddr = pos[AW-1:0];

  always_comb begin
    s1_nxt           = '0;
    s1_nxt.status    = sfr_pkg::ST_NONE;
    if (in_accept) begin
      case (req)
        sfr_pkg::REQ_TIMEOUT: s1_nxt.status = sfr_pkg::ST_TIMEOUT;
        sfr_pkg::REQ_READ: begin
          s1_nxt.status    = sfr_pkg::ST_READ;
          s1_nxt.frame_len = sfr_pkg::LEN_W'(count_r);
          s1_nxt.pkt_type  = (count_r != '0) ? first_r : '0;
          s1_nxt.rd_ok     = (pos < PW'(count_r)) && (pos < DEPTH_POS);
        end
        sfr_pkg::REQ_BYTE: begin
          if (frame_end) begin
            s1_nxt.status    = sfr_pkg::ST_DONE;
            s1_nxt.frame_len = sfr_pkg::LEN_W'(count_r);
            s1_nxt.pkt_type  = first_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= sfr_pkg::MODE_HUNT;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    if (in_accept) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      out_r       <= s1_r;
      out_rdata_r <= s1_r.rd_ok ? ram_rdata : '0;
    end
  end

  // Frame buffer. The read register only loads on an accepted request, so
  // its data stays put while the stage beside it waits.
  sfr_ram #(
    .WIDTH (sfr_pkg::BYTE_W),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (store_val),
    .re    (in_accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_status    = out_r.status;
  assign out_frame_len = out_r.frame_len;
  assign out_pkt_type  = out_r.pkt_type;
  assign out_read_data = out_rdata_r;

endmodule
